[rtl/tpc_pkg.sv]
// ---------------------------------------------------------------------------
// tpc_pkg - shared types and constants for the token pair counter
// Opcodes, sequencer states, scan status and scan control.
// ---------------------------------------------------------------------------
package tpc_pkg;

	localparam int TPC_TABLE_DEPTH = 1024;
	localparam int TPC_ID_BITS     = 16;
	localparam int TPC_COUNT_BITS  = 20;

	localparam logic [1:0] OP_CONTINUE = 2'd0;
	localparam logic [1:0] OP_RESTART  = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic hit;
		logic miss;
	} scan_status_t;

	typedef struct packed {
		logic start;
		logic active;
	} scan_ctrl_t;

endpackage

[rtl/token_pair_counter.sv]
// ---------------------------------------------------------------------------
// token_pair_counter - adjacent token pair frequency counter
// Counts (previous, current) token pairs in an insertion-ordered table and
// tracks the most frequent pair.
//
//   group  dir  payload (low bit first)
//   s_*    in   tdata: token_id   tuser: opcode
//   m_*    out  tdata: pair_count, best_first, best_second, best_count,
//                      entries_used, overflow
//
// A continuing token after a previous one searches the table: the scan reads
// one table entry per cycle through the single read port, a new pair is
// appended, a known pair is updated, and the result follows. Other requests
// go straight to the result. s_tready is high only in the idle state.
// A waiting result does not block the next request; a finished request holds
// until the output register is free. Reset empties the table at once.
// ---------------------------------------------------------------------------
module token_pair_counter #(
	parameter int TABLE_DEPTH = tpc_pkg::TPC_TABLE_DEPTH,
	parameter int ID_BITS     = tpc_pkg::TPC_ID_BITS,
	parameter int COUNT_BITS  = tpc_pkg::TPC_COUNT_BITS,
	localparam int UW         = $clog2(TABLE_DEPTH + 1),
	localparam int IN_W       = ((ID_BITS + 7) / 8) * 8,
	localparam int OUT_RAW    = 2 * COUNT_BITS + 2 * ID_BITS + UW + 1,
	localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // token_id
	input  logic [1:0]       s_tuser,  // opcode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // pair_count, best_first, best_second,
	                                   // best_count, entries_used, overflow
);
	import tpc_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;

	logic [ID_BITS-1:0]    prev_tok_q;
	logic                  have_prev_q;
	logic [2*ID_BITS-1:0]  key_q;
	logic [UW-1:0]         used_q;
	logic [AW-1:0]         best_idx_q;
	logic [COUNT_BITS-1:0] best_val_q;
	logic [2*ID_BITS-1:0]  best_key_q;
	logic                  overflow_q;
	logic [AW-1:0]         hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [COUNT_BITS-1:0] formed_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	logic                  accept;
	logic                  load_out;
	logic                  full;
	logic                  wr_key_en;
	logic                  wr_cnt_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [2*ID_BITS-1:0]  rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [AW-1:0]         scan_idx;
	scan_ctrl_t            scan_ctrl;
	scan_status_t          scan_st;
	logic                  upd_best;
	logic                  app_best;
	logic [ID_BITS-1:0]    tok;
	logic [1:0]            op;
	logic [OUT_RAW-1:0]    out_raw;

	assign tok    = s_tdata[ID_BITS-1:0];
	assign op     = s_tuser;
	assign accept = s_tvalid && s_tready;
	assign full   = (used_q == DEPTH_U);

	assign upd_best = (hit_cnt_q > best_val_q) ||
	                  ((hit_cnt_q == best_val_q) && (hit_idx_q < best_idx_q));
	assign app_best = (COUNT_BITS'(1) > best_val_q) ||
	                  ((COUNT_BITS'(1) == best_val_q) && (used_q[AW-1:0] < best_idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		load_out         = 1'b0;
		scan_ctrl.start  = 1'b0;
		scan_ctrl.active = 1'b0;
		wr_key_en        = 1'b0;
		wr_cnt_en        = 1'b0;
		wr_addr          = used_q[AW-1:0];
		wr_cnt           = COUNT_BITS'(1);
		unique case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				scan_ctrl.start = 1'b1;
				if (s_tvalid) begin
					if ((op == OP_CONTINUE) && have_prev_q) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SEARCH: begin
				scan_ctrl.active = 1'b1;
				if (scan_st.hit) begin
					state_d = ST_UPDATE;
				end else if (scan_st.miss) begin
					wr_key_en = !full;
					wr_cnt_en = !full;
					state_d   = ST_FINISH;
				end
			end
			ST_UPDATE: begin
				wr_cnt_en = 1'b1;
				wr_addr   = hit_idx_q;
				wr_cnt    = hit_cnt_q;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tok_q  <= '0;
			have_prev_q <= 1'b0;
			used_q      <= '0;
			best_idx_q  <= '0;
			best_val_q  <= '0;
			overflow_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (accept) begin
				prev_tok_q  <= tok;
				have_prev_q <= 1'b1;
				if (op[1]) begin
					used_q     <= '0;
					best_idx_q <= '0;
					best_val_q <= '0;
					overflow_q <= 1'b0;
				end
			end
			if (state_q == ST_SEARCH && scan_st.miss) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					used_q <= used_q + UW'(1);
					if (app_best) begin
						best_val_q <= COUNT_BITS'(1);
						best_idx_q <= used_q[AW-1:0];
					end
				end
			end
			if (state_q == ST_UPDATE && upd_best) begin
				best_val_q <= hit_cnt_q;
				best_idx_q <= hit_idx_q;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= {tok, prev_tok_q};
			formed_q <= '0;
		end
		if (state_q == ST_SEARCH && scan_st.hit) begin
			hit_idx_q <= scan_idx;
			hit_cnt_q <= (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
		end
		if (state_q == ST_SEARCH && scan_st.miss && !full) begin
			formed_q <= COUNT_BITS'(1);
			if (app_best) begin
				best_key_q <= key_q;
			end
		end
		if (state_q == ST_UPDATE) begin
			formed_q <= hit_cnt_q;
			if (upd_best) begin
				best_key_q <= key_q;
			end
		end
		if (load_out) begin
			m_tdata_q <= OUT_W'(out_raw);
		end
	end

	always_comb begin
		if (used_q != '0) begin
			out_raw = {overflow_q, used_q, best_val_q,
			           best_key_q[2*ID_BITS-1:ID_BITS], best_key_q[ID_BITS-1:0], formed_q};
		end else begin
			out_raw = {overflow_q, used_q, COUNT_BITS'(0), (2 * ID_BITS)'(0), formed_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tpc_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_BITS     (ID_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_table (
		.clk       (clk),
		.wr_key_en (wr_key_en),
		.wr_cnt_en (wr_cnt_en),
		.wr_addr   (wr_addr),
		.wr_key    (key_q),
		.wr_cnt    (wr_cnt),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_cnt    (rd_cnt)
	);

	tpc_scan #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (scan_ctrl),
		.used    (used_q),
		.key     (key_q),
		.rd_key  (rd_key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.hit_idx (scan_idx),
		.status  (scan_st)
	);

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_U)
		else $error("entry count beyond table depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> full)
		else $error("overflow raised with room in table");

	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0) |-> (best_val_q == '0))
		else $error("best count held with empty table");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (UW'(hit_idx_q) < used_q))
		else $error("hit index beyond used entries");

endmodule

[rtl/tpc_table.sv]
// ---------------------------------------------------------------------------
// tpc_table - pair key and count store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tpc_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ID_BITS     = 16,
	parameter int COUNT_BITS  = 20,
	localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_key_en,
	input  logic                  wr_cnt_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [2*ID_BITS-1:0]  wr_key,
	input  logic [COUNT_BITS-1:0] wr_cnt,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [2*ID_BITS-1:0]  rd_key,
	output logic [COUNT_BITS-1:0] rd_cnt
);

	logic [2*ID_BITS-1:0]  key_mem [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_cnt_en) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_cnt <= cnt_mem[rd_addr];
		end
	end

endmodule

[rtl/tpc_scan.sv]
// ---------------------------------------------------------------------------
// tpc_scan - linear key search unit
// Steps one table entry per cycle and compares each stored key.
// ---------------------------------------------------------------------------
module tpc_scan #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ID_BITS     = 16,
	localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int UW         = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tpc_pkg::scan_ctrl_t   ctrl,
	input  logic [UW-1:0]         used,
	input  logic [2*ID_BITS-1:0]  key,
	input  logic [2*ID_BITS-1:0]  rd_key,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	output logic [AW-1:0]         hit_idx,
	output tpc_pkg::scan_status_t status
);
	import tpc_pkg::*;

	logic [UW-1:0] idx_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          issue;
	logic          match;

	assign issue   = ctrl.active && (idx_q < used);
	assign rd_en   = issue;
	assign rd_addr = idx_q[AW-1:0];
	assign match   = vld_s1 && (rd_key == key);
	assign hit_idx = idx_s1;

	always_comb begin
		status.hit  = ctrl.active && match;
		status.miss = ctrl.active && !match && !(idx_q < used);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (ctrl.start) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + UW'(1);
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= idx_q[AW-1:0];
		end
	end

endmodule
